@@ rtl/npc_pkg.sv @@
// Shared types and constants of the nearest palette color search.
`default_nettype none
package npc_pkg;

	localparam int DEFAULT_PALETTE_DEPTH = 64;

	localparam int COLOR_W = 8;
	localparam int ENTRY_W = 3 * COLOR_W;
	localparam int SLOT_W  = 6;
	localparam int SIZE_W  = 7;
	localparam int DIST_W  = 18;
	localparam int SQ_W    = 2 * COLOR_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Start value of the running minimum, above any real distance.
	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 * 3);
	localparam logic [DIST_W-1:0] DIST_MAX   = DIST_W'(3 * 255 * 255);

	// Word index of the only register.
	localparam logic REG_PALETTE_SIZE = 1'b0;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

endpackage
`default_nettype wire

@@ rtl/npc_if.sv @@
// Valid/ready channel interfaces for palette requests and search results.
`default_nettype none
interface npc_req_if;
	import npc_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [SLOT_W-1:0]  entry_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source (output valid, kind, entry_index, red, green, blue, input ready);
	modport sink   (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if;
	import npc_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [SLOT_W-1:0] best_index;
	logic [DIST_W-1:0] best_distance;

	modport source (output valid, found, best_index, best_distance, input ready);
	modport sink   (input valid, found, best_index, best_distance, output ready);
endinterface
`default_nettype wire

@@ rtl/nearest_palette_color.sv @@
// Nearest palette color search: palette memory, scan sequencer and one distance unit.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+--------------------------------------------
//   req     | in  | valid/ready    | kind, entry_index, red, green, blue
//   rsp     | out | valid/ready    | found, best_index, best_distance
//   apb     | in  | psel/penable   | paddr, pwdata -> palette_size; prdata back
//
// A query scans min(palette_size, PALETTE_DEPTH) palette entries: the scan reads
// one palette entry per cycle from the single read port and feeds one distance
// unit (three squares and a sum) behind a registered read.
// Reset clears the sequencer and palette_size; the palette itself is not cleared.
// A finished result waits in the output register; a scan that ends while that
// register is still held stalls until the transfer happens. req.ready is low
// for the whole scan.
`default_nettype none
module nearest_palette_color #(
	parameter int PALETTE_DEPTH = npc_pkg::DEFAULT_PALETTE_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	npc_req_if.sink                      req,
	npc_rsp_if.source                    rsp,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [npc_pkg::PADDR_W-1:0]  paddr,
	input  wire  [npc_pkg::PDATA_W-1:0]  pwdata,
	output logic [npc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import npc_pkg::*;

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(PALETTE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
	                                            input logic [COLOR_W-1:0] b);
		logic [COLOR_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	state_t              state_q;
	logic [SIZE_W-1:0]   palette_size_q;

	logic [ENTRY_W-1:0]  palette_mem [PALETTE_DEPTH];

	logic [COLOR_W-1:0]  qr_q, qg_q, qb_q;
	logic [CW-1:0]       rd_cnt_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;

	logic [ENTRY_W-1:0]  rd_data_s1;
	logic [AW-1:0]       idx_s1;
	logic                v_s1_q;

	logic [SQ_W-1:0]     sq_r_s2, sq_g_s2, sq_b_s2;
	logic [AW-1:0]       idx_s2;
	logic                v_s2_q;

	logic [DIST_W-1:0]   best_d_q;
	logic [AW-1:0]       best_i_q;
	logic                found_q;

	logic                out_valid_q;
	logic                out_found_q;
	logic [SLOT_W-1:0]   out_index_q;
	logic [DIST_W-1:0]   out_dist_q;

	logic                req_xfer;
	logic                is_load;
	logic                is_query;
	logic                issue;
	logic                scan_done;
	logic                out_free;
	logic                cfg_wr;
	logic [DIST_W-1:0]   dist_sum;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign is_load   = req_xfer && (req.kind == KIND_LOAD);
	assign is_query  = req_xfer && (req.kind == KIND_QUERY);

	assign issue     = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
	assign scan_done = (state_q == ST_SCAN) && !issue && !v_s1_q && !v_s2_q;
	assign out_free  = !out_valid_q || rsp.ready;

	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	// Clamp the search length to the palette depth.
	always_comb begin
		if (int'(palette_size_q) > PALETTE_DEPTH) begin
			count_d = CW'(PALETTE_DEPTH);
		end else begin
			count_d = CW'(palette_size_q);
		end
	end

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PALETTE_SIZE);
	assign prdata = (paddr[2] == REG_PALETTE_SIZE) ? PDATA_W'(palette_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= '0;
		end else if (cfg_wr) begin
			palette_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Palette memory: written by loads, read by the scan.
	always_ff @(posedge clk) begin
		if (is_load && (int'(req.entry_index) < PALETTE_DEPTH)) begin
			palette_mem[AW'(req.entry_index)] <= {req.red, req.green, req.blue};
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= palette_mem[rd_cnt_q[AW-1:0]];
			idx_s1     <= rd_cnt_q[AW-1:0];
		end
	end

	// Distance unit, squares stage
	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			sq_r_s2 <= sq_diff(qr_q, rd_data_s1[ENTRY_W-1 -: COLOR_W]);
			sq_g_s2 <= sq_diff(qg_q, rd_data_s1[2*COLOR_W-1 -: COLOR_W]);
			sq_b_s2 <= sq_diff(qb_q, rd_data_s1[COLOR_W-1:0]);
			idx_s2  <= idx_s1;
		end
	end

	// Sequencer and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			count_q  <= '0;
			v_s1_q   <= 1'b0;
			v_s2_q   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
			unique case (state_q)
				ST_IDLE: begin
					if (is_query) begin
						rd_cnt_q <= '0;
						count_q  <= count_d;
						found_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (v_s2_q && (dist_sum <= best_d_q)) begin
						found_q <= 1'b1;
					end
					// Hold the finished search until the output register frees up.
					if (scan_done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			qr_q     <= req.red;
			qg_q     <= req.green;
			qb_q     <= req.blue;
			best_d_q <= DIST_START;
			best_i_q <= '0;
		end else if (v_s2_q && (dist_sum <= best_d_q)) begin
			best_d_q <= dist_sum;
			best_i_q <= idx_s2;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done && out_free) begin
			out_found_q <= found_q;
			out_index_q <= found_q ? SLOT_W'(best_i_q) : '0;
			out_dist_q  <= found_q ? best_d_q : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.found         = out_found_q;
	assign rsp.best_index    = out_index_q;
	assign rsp.best_distance = out_dist_q;

endmodule
`default_nettype wire

@@ rtl/npc_checker.sv @@
// Port-level checks for the nearest palette color search, bound to the top level.
`default_nettype none
module npc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          req_kind,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire                          rsp_found,
	input wire [npc_pkg::SLOT_W-1:0]    rsp_best_index,
	input wire [npc_pkg::DIST_W-1:0]    rsp_best_distance
);
	import npc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before its transfer");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			$stable(rsp_found) && $stable(rsp_best_index) && $stable(rsp_best_distance))
		else $error("stalled result changed");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_kind == KIND_QUERY) |=> !req_ready)
		else $error("request taken during a scan");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> (rsp_best_index == '0) && (rsp_best_distance == '0))
		else $error("empty search returned nonzero fields");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_best_distance <= DIST_MAX)
		else $error("distance out of range");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_kind          (req.kind),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_found         (rsp.found),
	.rsp_best_index    (rsp.best_index),
	.rsp_best_distance (rsp.best_distance)
);
`default_nettype wire
